>>> hdl/lfned_pkg.sv
// ----------------------------------------------------------------------------
// lfned_pkg: shared types and constants of the long file name entry decoder
// Command and status codes, field widths and the transaction structs that
// travel from the input register to the core and on to the result queue.
// ----------------------------------------------------------------------------
package lfned_pkg;

    localparam int CHARS_IN_ENTRY = 13;
    localparam int SHORT_NAME_LEN = 11;
    localparam int RESULT_DEPTH   = 4;

    localparam int SHORT_IDX_W = 4;
    localparam int CHAR_IDX_W  = 4;

    localparam logic [1:0] CMD_SHORT_BYTE = 2'd0;
    localparam logic [1:0] CMD_HEADER     = 2'd1;
    localparam logic [1:0] CMD_CHAR       = 2'd2;

    localparam logic [1:0] ST_CHAR      = 2'd0;
    localparam logic [1:0] ST_DONE      = 2'd1;
    localparam logic [1:0] ST_MISMATCH  = 2'd2;
    localparam logic [1:0] ST_NON_ASCII = 2'd3;

    localparam logic [15:0] PAD_CHAR   = 16'hFFFF;
    localparam int          LAST_FLAG_BIT = 6;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  short_name_byte;
        logic [7:0]  seq_num;
        logic [7:0]  entry_checksum;
        logic [15:0] ucs_char;
    } item_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic [1:0] status;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

>>> hdl/long_file_name_entry_decoder.sv
// ----------------------------------------------------------------------------
// long_file_name_entry_decoder: long file name entry decoder
// Item channel: item_valid/item_stall with command, short_name_byte, seq_num,
// entry_checksum and ucs_char; a transaction completes when item_valid is
// high and item_stall is low. Result channel: result_valid/result_stall with
// ascii_char, status and last_of_run, same rule.
// An accepted item lands in an input register and is decoded from there
// once the result queue has room; its results go through the queue, whose
// head drives the result port. Throughput is one item per cycle while
// item_stall is low; each item makes zero, one or two results and the
// result port moves at most one per cycle, so a two-result item takes two
// result transactions. A four-entry result queue decouples the two
// channels; item_stall rises only while the input register holds an item
// and the queue has fewer than two free entries, i.e. when results come in
// faster than the receiver takes them. A stalled result holds its
// fields. Reset clears the checksum, indices, entry flags, halt flag and the
// queue; no result is valid after reset.
// ----------------------------------------------------------------------------
module long_file_name_entry_decoder
    import lfned_pkg::*;
#(
    parameter int RESULT_QUEUE_DEPTH = RESULT_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  short_name_byte,
    input  logic [7:0]  seq_num,
    input  logic [7:0]  entry_checksum,
    input  logic [15:0] ucs_char,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  ascii_char,
    output logic [1:0]  status,
    output logic        last_of_run
);

    item_t   item_reg;
    logic    stage_valid_reg, stage_valid_next;
    logic    accept;
    logic    fire;
    logic    has_room;
    push_t   push;
    result_t head;

    assign fire       = stage_valid_reg && has_room;
    assign item_stall = stage_valid_reg && !has_room;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{command, short_name_byte, seq_num, entry_checksum, ucs_char};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    lfned_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .push  (push)
    );

    lfned_result_queue #(
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .has_room   (has_room),
        .head_valid (result_valid),
        .head       (head),
        .head_taken (!result_stall)
    );

    assign ascii_char  = head.ascii_char;
    assign status      = head.status;
    assign last_of_run = head.last_of_run;

endmodule

>>> hdl/lfned_core.sv
// ----------------------------------------------------------------------------
// lfned_core: walk state and per-transaction decode
// Holds the short-name checksum and entry state, and turns one registered
// transaction into up to two results in a single pass.
// ----------------------------------------------------------------------------
module lfned_core
    import lfned_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  fire,
    input  item_t item,
    output push_t push
);

    logic [7:0]             acc_reg, acc_next;
    logic [SHORT_IDX_W-1:0] sidx_reg, sidx_next;
    logic [CHAR_IDX_W-1:0]  cidx_reg, cidx_next;
    logic                   open_reg, open_next;
    logic                   final_reg, final_next;
    logic                   halted_reg, halted_next;

    logic                   restart;
    logic [7:0]             acc_base;
    logic [7:0]             acc_sum;
    logic [SHORT_IDX_W-1:0] sidx_base;
    logic [CHAR_IDX_W-1:0]  cidx_inc;

    assign restart = halted_reg || (sidx_reg == '0)
                     || (sidx_reg >= SHORT_IDX_W'(SHORT_NAME_LEN));
    assign acc_base  = restart ? 8'd0 : acc_reg;
    assign sidx_base = restart ? '0 : sidx_reg;
    // rotate right by one, then add
    assign acc_sum   = {acc_base[0], acc_base[7:1]} + item.short_name_byte;
    assign cidx_inc  = cidx_reg + CHAR_IDX_W'(1);

    always_comb
    begin
        acc_next    = acc_reg;
        sidx_next   = sidx_reg;
        cidx_next   = cidx_reg;
        open_next   = open_reg;
        final_next  = final_reg;
        halted_next = halted_reg;
        push        = '0;
        if (fire)
        begin
            unique case (item.command)
                CMD_SHORT_BYTE:
                begin
                    acc_next  = acc_sum;
                    sidx_next = sidx_base + SHORT_IDX_W'(1);
                    if (restart)
                    begin
                        halted_next = 1'b0;
                        open_next   = 1'b0;
                        final_next  = 1'b0;
                        cidx_next   = '0;
                    end
                end
                CMD_HEADER:
                begin
                    if (!halted_reg)
                    begin
                        if (item.entry_checksum != acc_reg)
                        begin
                            push.count  = 2'd1;
                            push.first  = '{8'd0, ST_MISMATCH, 1'b1};
                            halted_next = 1'b1;
                            open_next   = 1'b0;
                        end
                        else
                        begin
                            open_next  = 1'b1;
                            final_next = item.seq_num[LAST_FLAG_BIT];
                            cidx_next  = '0;
                        end
                    end
                end
                CMD_CHAR:
                begin
                    if (!halted_reg && open_reg)
                    begin
                        if (item.ucs_char == PAD_CHAR)
                        begin
                            open_next = 1'b0;
                            if (final_reg)
                            begin
                                push.count  = 2'd1;
                                push.first  = '{8'd0, ST_DONE, 1'b1};
                                halted_next = 1'b1;
                            end
                        end
                        else if (item.ucs_char[15:8] != 8'd0)
                        begin
                            push.count  = 2'd1;
                            push.first  = '{8'd0, ST_NON_ASCII, 1'b1};
                            halted_next = 1'b1;
                            open_next   = 1'b0;
                        end
                        else
                        begin
                            cidx_next   = cidx_inc;
                            push.count  = 2'd1;
                            push.first  = '{item.ucs_char[7:0], ST_CHAR, 1'b1};
                            if (cidx_inc >= CHAR_IDX_W'(CHARS_IN_ENTRY))
                            begin
                                open_next = 1'b0;
                                if (final_reg)
                                begin
                                    push.count  = 2'd2;
                                    push.first  = '{item.ucs_char[7:0], ST_CHAR, 1'b0};
                                    push.second = '{8'd0, ST_DONE, 1'b1};
                                    halted_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            sidx_reg   <= '0;
            cidx_reg   <= '0;
            open_reg   <= 1'b0;
            final_reg  <= 1'b0;
            halted_reg <= 1'b0;
        end
        else
        begin
            acc_reg    <= acc_next;
            sidx_reg   <= sidx_next;
            cidx_reg   <= cidx_next;
            open_reg   <= open_next;
            final_reg  <= final_next;
            halted_reg <= halted_next;
        end
    end

    // nothing but a new short name gets through after a halt
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && halted_reg && (item.command != CMD_SHORT_BYTE) |-> push.count == 2'd0)
        else $error("result produced while halted");

    // a pair is always the last character followed by name complete
    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> (push.first.status == ST_CHAR)
                               && (push.second.status == ST_DONE))
        else $error("malformed result pair");

    // every non-character result halts the walk
    a_status_halts: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd1 && push.first.status != ST_CHAR |=> halted_reg)
        else $error("terminal result without halt");

    a_char_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> cidx_reg < CHAR_IDX_W'(CHARS_IN_ENTRY))
        else $error("character index past entry length while open");

endmodule

>>> hdl/lfned_result_queue.sv
// ----------------------------------------------------------------------------
// lfned_result_queue: small result queue
// Takes up to two results per cycle from the core and hands out one per
// transaction on the result channel; DEPTH must be a power of two, at least 2.
// ----------------------------------------------------------------------------
module lfned_result_queue
    import lfned_pkg::*;
#(
    parameter int DEPTH = RESULT_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    has_room,
    output logic    head_valid,
    output result_t head,
    input  logic    head_taken
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [PW-1:0]   wr_ptr_second;
    logic            pop;

    assign has_room      = count_reg <= CW'(DEPTH - 2);
    assign head_valid    = count_reg != '0;
    assign head          = entry_reg[rd_ptr_reg];
    assign pop           = head_valid && head_taken;
    assign wr_ptr_second = wr_ptr_reg + PW'(1);
    assign wr_ptr_next   = wr_ptr_reg + PW'(push.count);
    assign rd_ptr_next   = rd_ptr_reg + PW'(pop);
    assign count_next    = count_reg + CW'(push.count) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= CW'(DEPTH) - CW'(push.count))
        else $error("result queue overflow");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CW'(DEPTH) |-> (wr_ptr_reg - rd_ptr_reg) == PW'(count_reg))
        else $error("queue pointers disagree with count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the long file name entry decoder
// Drives short names and long-name entries (well-formed, padded, corrupted
// and mixed with noise) under random idling and stalling on both channels.
// Every accepted input transaction goes through a cycle-free model of the
// decoder, and the results it predicts are matched in order against the
// result port.
// ----------------------------------------------------------------------------
module tb;
    import lfned_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 30;
    localparam int ITEM_TARGET = 950;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 100;

    class lfn_scoreboard;
        logic [7:0] name_sum;
        logic [3:0] name_len;
        logic [3:0] chars_taken;
        bit         entry_open;
        bit         entry_last;
        bit         halted;
        result_t    decoded_q[$];
        int         errors;
        int         n_items;
        int         n_chars;
        int         n_done;
        int         n_mismatch;
        int         n_non_ascii;

        function new();
            name_sum    = '0;
            name_len    = '0;
            chars_taken = '0;
            entry_open  = 1'b0;
            entry_last  = 1'b0;
            halted      = 1'b0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void push(logic [7:0] ch, logic [1:0] st, logic last);
            result_t r;
            r.ascii_char  = ch;
            r.status      = st;
            r.last_of_run = last;
            decoded_q.push_back(r);
        endfunction

        // advance the decoder state by one accepted input transaction
        function void decode_item(item_t it);
            n_items++;
            if (it.command == CMD_SHORT_BYTE)
            begin
                if (halted || name_len == 0 || name_len >= SHORT_NAME_LEN)
                begin
                    halted      = 1'b0;
                    entry_open  = 1'b0;
                    entry_last  = 1'b0;
                    chars_taken = '0;
                    name_sum    = '0;
                    name_len    = '0;
                end
                name_sum = {name_sum[0], name_sum[7:1]} + it.short_name_byte;
                name_len++;
                return;
            end
            if (halted || (it.command != CMD_HEADER && it.command != CMD_CHAR))
                return;
            if (it.command == CMD_HEADER)
            begin
                if (it.entry_checksum != name_sum)
                begin
                    push(8'h00, ST_MISMATCH, 1'b1);
                    halted     = 1'b1;
                    entry_open = 1'b0;
                end
                else
                begin
                    entry_open  = 1'b1;
                    entry_last  = it.seq_num[LAST_FLAG_BIT];
                    chars_taken = '0;
                end
                return;
            end
            if (!entry_open)
                return;
            if (it.ucs_char == PAD_CHAR)
            begin
                entry_open = 1'b0;
                if (entry_last)
                begin
                    push(8'h00, ST_DONE, 1'b1);
                    halted = 1'b1;
                end
                return;
            end
            if (it.ucs_char[15:8] != 8'h00)
            begin
                push(8'h00, ST_NON_ASCII, 1'b1);
                halted     = 1'b1;
                entry_open = 1'b0;
                return;
            end
            chars_taken++;
            if (chars_taken >= CHARS_IN_ENTRY)
            begin
                entry_open = 1'b0;
                if (entry_last)
                begin
                    push(it.ucs_char[7:0], ST_CHAR, 1'b0);
                    push(8'h00, ST_DONE, 1'b1);
                    halted = 1'b1;
                    return;
                end
            end
            push(it.ucs_char[7:0], ST_CHAR, 1'b1);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void match_result(result_t got);
            result_t want;
            if (decoded_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got char %0h status %0d last %0b",
                             $time, got.ascii_char, got.status, got.last_of_run);
                return;
            end
            want = decoded_q.pop_front();
            case (want.status)
                ST_CHAR:      n_chars++;
                ST_DONE:      n_done++;
                ST_MISMATCH:  n_mismatch++;
                default:      n_non_ascii++;
            endcase
            compare_field("ascii_char", want.ascii_char, got.ascii_char);
            compare_field("status", {6'd0, want.status}, {6'd0, got.status});
            compare_field("last_of_run", {7'd0, want.last_of_run}, {7'd0, got.last_of_run});
        endfunction
    endclass

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        item_valid      = 1'b0;
    logic        item_stall;
    logic [1:0]  command         = CMD_SHORT_BYTE;
    logic [7:0]  short_name_byte = '0;
    logic [7:0]  seq_num         = '0;
    logic [7:0]  entry_checksum  = '0;
    logic [15:0] ucs_char        = '0;
    logic        result_valid;
    logic        result_stall    = 1'b0;
    logic [7:0]  ascii_char;
    logic [1:0]  status;
    logic        last_of_run;

    lfn_scoreboard sb;
    bit quiet     = 1'b0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int offered   = 0;
    int cycles    = 0;

    long_file_name_entry_decoder i_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: timed out after %0d cycles", cycles);
            $display("tb: done, errors");
            $finish;
        end
    end

    // accepted transactions on both channels
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.decode_item('{command, short_name_byte, seq_num, entry_checksum, ucs_char});
        if (rst_n && result_valid && !result_stall)
            sb.match_result('{ascii_char, status, last_of_run});
    end

    // receiver: random stalls, long hold-off on request
    always @(negedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen    <= hold_asks;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (quiet)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    // one input transaction; header checksum taken from the running sum, corrupted when bad_sum is set
    task automatic offer(logic [1:0] cmd, logic [15:0] val, bit bad_sum);
        item_t it;
        @(negedge clk);
        if (!quiet)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                item_valid <= 1'b0;
                @(negedge clk);
            end
        it.command         = cmd;
        it.short_name_byte = 8'($urandom);
        it.seq_num         = 8'($urandom);
        it.entry_checksum  = 8'($urandom);
        it.ucs_char        = 16'($urandom);
        case (cmd)
            CMD_SHORT_BYTE: it.short_name_byte = val[7:0];
            CMD_HEADER:
            begin
                it.seq_num        = val[7:0];
                it.entry_checksum = bad_sum ? sb.name_sum ^ 8'($urandom_range(1, 255))
                                            : sb.name_sum;
            end
            CMD_CHAR:       it.ucs_char = val;
            default:        ;
        endcase
        item_valid      <= 1'b1;
        command         <= it.command;
        short_name_byte <= it.short_name_byte;
        seq_num         <= it.seq_num;
        entry_checksum  <= it.entry_checksum;
        ucs_char        <= it.ucs_char;
        do @(posedge clk); while (item_stall);
        offered++;
    endtask

    task automatic wait_empty();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic send_name();
        int         short_n;
        int         n_entries;
        int         chars;
        logic [7:0] seq;
        short_n = ($urandom_range(99) < 10) ? $urandom_range(1, SHORT_NAME_LEN + 2)
                                            : SHORT_NAME_LEN;
        for (int b = 0; b < short_n; b++)
            offer(CMD_SHORT_BYTE, 16'($urandom), 1'b0);
        n_entries = $urandom_range(1, 3);
        for (int e = 1; e <= n_entries; e++)
        begin
            seq = 8'($urandom);
            seq[LAST_FLAG_BIT] = (e == n_entries);
            offer(CMD_HEADER, {8'h00, seq}, $urandom_range(99) < 5);
            chars = ($urandom_range(99) < 30) ? $urandom_range(0, CHARS_IN_ENTRY - 1)
                                              : CHARS_IN_ENTRY;
            for (int c = 0; c < chars; c++)
            begin
                if ($urandom_range(99) < 2)
                    offer(2'($urandom), 16'($urandom), 1'($urandom_range(1)));
                if ($urandom_range(99) < 3)
                    offer(CMD_CHAR, 16'($urandom_range(16'h0100, 16'hFFFE)), 1'b0);
                else
                    offer(CMD_CHAR, 16'($urandom_range(0, 255)), 1'b0);
            end
            if (chars < CHARS_IN_ENTRY)
                offer(CMD_CHAR, PAD_CHAR, 1'b0);
        end
    endtask

    initial
    begin
        int names;
        sb = new();
        names = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corners
        offer(CMD_UNUSED, PAD_CHAR, 1'b0);
        offer(CMD_CHAR, 16'h0041, 1'b0);          // no entry open
        offer(CMD_SHORT_BYTE, 16'h00FF, 1'b0);
        offer(CMD_SHORT_BYTE, 16'h0000, 1'b0);
        offer(CMD_SHORT_BYTE, 16'h0080, 1'b0);
        offer(CMD_HEADER, 16'h00FF, 1'b0);        // partial short name, last entry
        offer(CMD_CHAR, 16'h0000, 1'b0);
        offer(CMD_CHAR, 16'h00FF, 1'b0);
        offer(CMD_HEADER, 16'h0040, 1'b0);        // drops the open entry
        offer(CMD_CHAR, 16'h007E, 1'b0);
        offer(CMD_CHAR, PAD_CHAR, 1'b0);          // name complete
        offer(CMD_CHAR, 16'h0041, 1'b0);          // ignored while halted
        offer(CMD_HEADER, 16'h0040, 1'b0);
        offer(CMD_SHORT_BYTE, 16'h0055, 1'b0);    // new short name
        offer(CMD_HEADER, 16'h0000, 1'b1);        // checksum mismatch
        offer(CMD_SHORT_BYTE, 16'h00AA, 1'b0);
        offer(CMD_HEADER, 16'h0000, 1'b0);
        offer(CMD_CHAR, 16'h0100, 1'b0);          // non-ascii
        offer(CMD_SHORT_BYTE, 16'h0001, 1'b0);
        offer(CMD_HEADER, 16'h00BF, 1'b0);        // not the last entry
        offer(CMD_CHAR, 16'hFFFE, 1'b0);
        wait_empty();

        while (offered < ITEM_TARGET)
        begin
            names++;
            quiet = (names >= 8 && names < 12);
            if (names % 7 == 3)
                hold_asks++;
            if (names % 9 == 5)
                wait_empty();
            if ($urandom_range(99) < 10)
                offer(2'($urandom), 16'($urandom), 1'($urandom_range(1)));
            send_name();
        end
        quiet = 1'b0;

        wait_empty();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("tb: %0d input transactions over %0d names, %0d results checked",
                 sb.n_items, names, sb.n_chars + sb.n_done + sb.n_mismatch + sb.n_non_ascii);
        $display("tb: %0d chars, %0d names complete, %0d checksum mismatches, %0d non-ascii",
                 sb.n_chars, sb.n_done, sb.n_mismatch, sb.n_non_ascii);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> long_file_name_entry_decoder.f
hdl/lfned_pkg.sv
hdl/lfned_core.sv
hdl/lfned_result_queue.sv
hdl/long_file_name_entry_decoder.sv
tb/sv/tb.sv
